FILE: src/aftm_pkg.sv
// ----------------------------------------------------------------------------
// ACES filmic tone map package
// Fixed-point formats, curve constants and pipeline dimensions shared by the
// tone mapping pipeline.
// ----------------------------------------------------------------------------
package aftm_pkg;

   // Number formats of the channels and of the exposure gain.
   localparam int IN_FRAC_BITS  = 8;
   localparam int OUT_FRAC_BITS = 12;
   localparam int NUM_CH        = 3;
   localparam int IN_W          = 16;
   localparam int GAIN_W        = 16;
   localparam int GAIN_FRAC     = 12;

   // The scaled value x is unsigned Q4.16 and saturates just under 16.0.
   localparam int X_FRAC  = 16;
   localparam int X_W     = 20;
   localparam int X_SHIFT = IN_FRAC_BITS + GAIN_FRAC - X_FRAC;
   localparam int PROD_W  = IN_W + GAIN_W;
   localparam logic [X_W-1:0] X_MAX = {X_W{1'b1}};

   // Curve constants in Q.16, rounded to nearest.
   localparam int K_W = 18;
   localparam logic [K_W-1:0] K_A = 18'd164495;
   localparam logic [K_W-1:0] K_B = 18'd1966;
   localparam logic [K_W-1:0] K_C = 18'd159252;
   localparam logic [K_W-1:0] K_D = 18'd38666;
   localparam logic [K_W-1:0] K_E = 18'd9175;

   // Inner terms (k*x + k' in Q.32), numerator and denominator (Q.48).
   localparam int TERM_W  = 39;
   localparam int POLY_W  = 60;
   localparam int TRUNC   = 16;
   localparam int NT_W    = POLY_W - TRUNC;

   // Dividend: truncated numerator scaled by the output fraction, plus half
   // the divisor for round to nearest.
   localparam int OUT_W      = OUT_FRAC_BITS + 1;
   localparam int DIVD_W     = NT_W + OUT_FRAC_BITS + 1;
   localparam int DIV_STAGES = OUT_W;
   localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << OUT_FRAC_BITS;

   // Multiply, curve terms, polynomials, dividend set-up, then one stage per
   // quotient bit.
   localparam int FRONT_STAGES = 4;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << GAIN_FRAC;

   localparam int REQ_TDATA_W = ((NUM_CH * IN_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((NUM_CH * OUT_W + 7) / 8) * 8;

   typedef logic [OUT_W-1:0] quo_type;

endpackage

FILE: src/aces_film_tone_map_top.sv
// ----------------------------------------------------------------------------
// ACES filmic tone mapper
// Scales each HDR channel by the exposure gain and maps it through the fitted
// filmic curve x(2.51x+0.03)/(x(2.43x+0.59)+0.14), clamped to 0..1 in Q1.12.
//
// Usage:
// - req_* carries one pixel per transfer: red, green and blue in unsigned
//   Q8.8. rsp_* returns the tone mapped pixel, each channel in Q1.12 where
//   4096 stands for 1.0. Results leave in the order the pixels arrived.
// - csr_* writes the exposure gain (unsigned Q4.12). It is always ready and
//   should only be written while no pixel is in flight.
// - A req transfer passes through three multiply stages, one dividend set-up
//   stage and a 13 stage restoring divider that resolves one quotient bit per
//   stage before the result is offered.
// - Throughput is one pixel per clock. Each stage holds its item until the
//   next stage can take it, so empty stages close up while rsp_tready is
//   low and req_tready only falls once the whole pipeline is full.
// - Reset empties the pipeline and sets the gain to 1.0.
// ----------------------------------------------------------------------------
module aces_film_tone_map_top
   import aftm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [GAIN_W-1:0]      csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // red_in [15:0], green_in [31:16], blue_in [47:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // red_out [12:0], green_out [25:13], blue_out [38:26], zero padding above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [GAIN_W-1:0]     gain_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;

   logic [PROD_W-1:0] prod_ff [NUM_CH];
   logic [PROD_W-1:0] prod_in [NUM_CH];
   logic [X_W-1:0]    x_ff    [NUM_CH];
   logic [X_W-1:0]    x_in    [NUM_CH];
   logic [TERM_W-1:0] ta_ff   [NUM_CH];
   logic [TERM_W-1:0] ta_in   [NUM_CH];
   logic [TERM_W-1:0] tc_ff   [NUM_CH];
   logic [TERM_W-1:0] tc_in   [NUM_CH];
   logic [POLY_W-1:0] num_ff  [NUM_CH];
   logic [POLY_W-1:0] num_in  [NUM_CH];
   logic [POLY_W-1:0] den_ff  [NUM_CH];
   logic [POLY_W-1:0] den_in  [NUM_CH];

   // Divider pipeline; entry 0 is the dividend set-up stage.
   logic [DIVD_W-1:0] rem_ff [DIV_STAGES+1][NUM_CH];
   logic [NT_W-1:0]   dvs_ff [DIV_STAGES+1][NUM_CH];
   logic              sat_ff [DIV_STAGES+1][NUM_CH];
   quo_type           quo_ff [DIV_STAGES+1][NUM_CH];

   logic [PROD_W-1:0] xs;
   logic [NT_W-1:0]   num_t;
   logic [DIVD_W-1:0] rem_in [NUM_CH];
   logic [NT_W-1:0]   dvs_in [NUM_CH];
   logic              sat_in [NUM_CH];
   quo_type           res    [NUM_CH];

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_valid) begin
         gain_ff <= csr_data;
      end
   end

   // A stage may load when it is empty or when its item moves on.
   assign adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;

   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = adv[0];

   // Front stages: exposure multiply, curve terms, polynomials, dividend.
   always_comb begin
      xs     = '0;
      num_t  = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         prod_in[c] = PROD_W'(req_tdata[c*IN_W +: IN_W]) * PROD_W'(gain_ff);

         xs = prod_ff[c] >> X_SHIFT;
         if (|xs[PROD_W-1:X_W]) begin
            x_in[c] = X_MAX;
         end else begin
            x_in[c] = xs[X_W-1:0];
         end
         // The inner terms travel with the x they were formed from.
         ta_in[c] = TERM_W'(K_A) * TERM_W'(x_in[c]) + (TERM_W'(K_B) << X_FRAC);
         tc_in[c] = TERM_W'(K_C) * TERM_W'(x_in[c]) + (TERM_W'(K_D) << X_FRAC);

         num_in[c] = POLY_W'(x_ff[c]) * POLY_W'(ta_ff[c]);
         den_in[c] = POLY_W'(x_ff[c]) * POLY_W'(tc_ff[c])
                   + (POLY_W'(K_E) << (2 * X_FRAC));

         // When the curve reaches one the quotient is not needed.
         sat_in[c] = (num_ff[c] >= den_ff[c]);
         num_t     = num_ff[c][POLY_W-1:TRUNC];
         dvs_in[c] = den_ff[c][POLY_W-1:TRUNC];
         rem_in[c] = (DIVD_W'(num_t) << OUT_FRAC_BITS) + DIVD_W'(dvs_in[c] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (adv[0]) begin
            prod_ff[c] <= prod_in[c];
         end
         if (adv[1]) begin
            x_ff[c]  <= x_in[c];
            ta_ff[c] <= ta_in[c];
            tc_ff[c] <= tc_in[c];
         end
         if (adv[2]) begin
            num_ff[c] <= num_in[c];
            den_ff[c] <= den_in[c];
         end
         if (adv[3]) begin
            rem_ff[0][c] <= rem_in[c];
            dvs_ff[0][c] <= dvs_in[c];
            sat_ff[0][c] <= sat_in[c];
            quo_ff[0][c] <= '0;
         end
      end
   end

   // Restoring divider, most significant quotient bit first.
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      localparam int BIT = DIV_STAGES - j;

      logic [DIVD_W-1:0] sub_in [NUM_CH];
      logic [DIVD_W:0]   diff   [NUM_CH];

      always_comb begin
         for (int c = 0; c < NUM_CH; c++) begin
            sub_in[c] = DIVD_W'(dvs_ff[j-1][c]) << BIT;
            diff[c]   = {1'b0, rem_ff[j-1][c]} - {1'b0, sub_in[c]};
         end
      end

      always_ff @(posedge clock) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (adv[FRONT_STAGES - 1 + j]) begin
               dvs_ff[j][c] <= dvs_ff[j-1][c];
               sat_ff[j][c] <= sat_ff[j-1][c];
               if (!diff[c][DIVD_W]) begin
                  rem_ff[j][c] <= diff[c][DIVD_W-1:0];
                  quo_ff[j][c] <= quo_ff[j-1][c] | (OUT_W'(1) << BIT);
               end else begin
                  rem_ff[j][c] <= rem_ff[j-1][c];
                  quo_ff[j][c] <= quo_ff[j-1][c];
               end
            end
         end
      end
   end

   // Clamp to 1.0 and pack the result.
   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         if (sat_ff[DIV_STAGES][c] || (quo_ff[DIV_STAGES][c] > ONE_OUT)) begin
            res[c] = ONE_OUT;
         end else begin
            res[c] = quo_ff[DIV_STAGES][c];
         end
         rsp_tdata[c*OUT_W +: OUT_W] = res[c];
      end
   end

   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ACES filmic tone mapper testbench
// Streams HDR pixels into the tone mapper under several exposure gains and
// compares every mapped pixel, channel by channel, with a fixed-point
// prediction of the filmic curve. Both stream sides idle and stall at random,
// and one phase holds the result side off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import aftm_pkg::*;

   localparam int PIPE_LATENCY = 17;
   localparam int CLK_HALF     = 5;

   // Curve constants in Q.16.
   localparam longint unsigned CURVE_A = 164495;
   localparam longint unsigned CURVE_B = 1966;
   localparam longint unsigned CURVE_C = 159252;
   localparam longint unsigned CURVE_D = 38666;
   localparam longint unsigned CURVE_E = 9175;
   localparam longint unsigned X_SAT   = 64'hF_FFFF;
   localparam longint unsigned OUT_ONE = 64'd1 << OUT_FRAC_BITS;

   typedef logic [NUM_CH-1:0][IN_W-1:0]  hdr_pixel_type;
   typedef logic [NUM_CH-1:0][OUT_W-1:0] mapped_pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [GAIN_W-1:0]      csr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [GAIN_W-1:0] exposure_gain_q412;
   mapped_pixel_type  mapped_q[$];
   int                mismatch_count;
   int                rsp_hold_left;
   int                rsp_stall_left;
   bit                steady_flow;

   string             chan_name[NUM_CH] = '{"red_out", "green_out", "blue_out"};
   mapped_pixel_type  got_pixel;
   mapped_pixel_type  want_pixel;

   aces_film_tone_map_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   initial begin
      #5_000_000;
      $display("** aces_film_tone_map_top: FAILED **");
      $finish;
   end

   // Fixed-point filmic curve for one channel at the given gain.
   function automatic logic [OUT_W-1:0] filmic_channel(logic [IN_W-1:0] radiance,
                                                       logic [GAIN_W-1:0] gain);
      longint unsigned x;
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      x = (longint'(radiance) * longint'(gain)) >> (IN_FRAC_BITS + 12 - 16);
      if (x > X_SAT) x = X_SAT;
      num = x * (CURVE_A * x + (CURVE_B << 16));
      den = x * (CURVE_C * x + (CURVE_D << 16)) + (CURVE_E << 32);
      if (num >= den) return OUT_W'(OUT_ONE);
      num = num >> 16;
      den = den >> 16;
      q = ((num << OUT_FRAC_BITS) + (den >> 1)) / den;
      if (q > OUT_ONE) q = OUT_ONE;
      return OUT_W'(q);
   endfunction

   function automatic mapped_pixel_type map_pixel(hdr_pixel_type pixel);
      mapped_pixel_type result;
      for (int ch = 0; ch < NUM_CH; ch++)
         result[ch] = filmic_channel(pixel[ch], exposure_gain_q412);
      return result;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int stall_length();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [IN_W-1:0] random_radiance();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return IN_W'($urandom_range(0, 16'hFFFF));
      if (pick < 65) return IN_W'($urandom_range(0, 16'h0A00));
      if (pick < 80) return IN_W'($urandom_range(0, 16'h0200));
      if (pick < 92) begin
         case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h8000;
            default: return 16'h7FFF;
         endcase
      end
      return IN_W'(1) << $urandom_range(0, IN_W - 1);
   endfunction

   // Result side: long hold-off first, then free flow or random stalls.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready = 1'b0;
         rsp_hold_left--;
      end else if (steady_flow) begin
         rsp_tready = 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_tready = 1'b0;
         rsp_stall_left--;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_tready = 1'b0;
         rsp_stall_left = stall_length() - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pixel = mapped_pixel_type'(rsp_tdata[NUM_CH*OUT_W-1:0]);
         if (mapped_q.size() == 0) begin
            $error("mapped pixel %h arrived with none expected", got_pixel);
            mismatch_count++;
         end else begin
            want_pixel = mapped_q.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (got_pixel[ch] !== want_pixel[ch]) begin
                  $error("%s: expected %0d, got %0d", chan_name[ch], want_pixel[ch],
                         got_pixel[ch]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // The pixel is offered from a falling edge and stays until a transfer.
   task automatic send_pixel(hdr_pixel_type pixel);
      int gap;
      gap = (steady_flow || $urandom_range(0, 99) < 65) ? 0 : stall_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pixel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mapped_q.push_back(map_pixel(pixel));
   endtask

   task automatic send_rgb(logic [IN_W-1:0] red, logic [IN_W-1:0] green,
                           logic [IN_W-1:0] blue);
      send_pixel({blue, green, red});
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (mapped_q.size() != 0) @(posedge clock);
   endtask

   // The gain is only changed once nothing is left in flight.
   task automatic write_exposure(logic [GAIN_W-1:0] gain);
      drain_pipeline();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = gain;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      exposure_gain_q412 = gain;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_reset_gain_corners();
      send_rgb(16'h0000, 16'h0000, 16'h0000);
      send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_rgb(16'h0001, 16'h0100, 16'h0800);
      // Around the point where the curve reaches one.
      send_rgb(16'h073E, 16'h0740, 16'h0730);
      send_rgb(16'h0010, 16'h0040, 16'h0080);
      send_rgb(16'h1000, 16'h8000, 16'h7FFF);
      send_rgb(16'h5555, 16'hAAAA, 16'h00FF);
      send_rgb(16'h0004, 16'h0002, 16'h0008);
   endtask

   task automatic test_gain_extremes();
      write_exposure(16'h0000);
      send_rgb(16'hFFFF, 16'h1234, 16'h0001);
      send_rgb(16'h8000, 16'h0100, 16'h0000);
      write_exposure(16'hFFFF);
      send_rgb(16'hFFFF, 16'h0001, 16'h0010);
      send_rgb(16'h0000, 16'h0100, 16'h0004);
      write_exposure(16'h0001);
      send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_rgb(16'h0100, 16'h1000, 16'h0010);
   endtask

   task automatic test_random_pixels();
      logic [GAIN_W-1:0] gain;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: gain = GAIN_W'($urandom_range(0, 16'hFFFF));
            1: gain = 16'h1000;
            2: gain = 16'h0400;
            3: gain = 16'hFFFF;
            default: gain = GAIN_W'($urandom_range(1, 16'h0100));
         endcase
         write_exposure(gain);
         // One phase runs with neither side pausing.
         steady_flow = (phase == 1);
         for (int n = 0; n < 64; n++)
            send_rgb(random_radiance(), random_radiance(), random_radiance());
         steady_flow = 1'b0;
      end
   endtask

   task automatic test_full_pipeline_stall();
      write_exposure(GAIN_W'($urandom_range(16'h0800, 16'h4000)));
      steady_flow = 1'b1;
      @(negedge clock);
      rsp_hold_left = 80;
      for (int n = 0; n < 40; n++)
         send_rgb(random_radiance(), random_radiance(), random_radiance());
      steady_flow = 1'b0;
      drain_pipeline();
   endtask

   initial begin
      reset              = 1'b1;
      csr_valid          = 1'b0;
      csr_data           = '0;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      rsp_hold_left      = 0;
      rsp_stall_left     = 0;
      steady_flow        = 1'b0;
      mismatch_count     = 0;
      exposure_gain_q412 = GAIN_W'(4096);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_gain_corners();
      test_gain_extremes();
      test_random_pixels();
      test_full_pipeline_stall();

      drain_pipeline();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && mapped_q.size() == 0)
         $display("** aces_film_tone_map_top: PASSED **");
      else
         $display("** aces_film_tone_map_top: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
src/aftm_pkg.sv
src/aces_film_tone_map_top.sv
bench/tb_top.sv
